FILE: design/midi_track_event_parser_top_defines.svh
// ----------------------------------------------------------------------------
// MIDI track event parser assertion macros
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge out of reset.
`define MTEP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// An implication whose consequent must hold the cycle after the antecedent.
`define MTEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTEP_ASSERT(lbl, prop, msg)
`define MTEP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/mtep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Types, codes and small arithmetic helpers shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtep_pkg;

  localparam int unsigned MAX_LENGTH_BYTES_DEF = 4;

  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_MTC       = 8'hF1;
  localparam logic [7:0] ST_SONG_POS  = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
  localparam logic [7:0] ST_EOX       = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;

  localparam logic [7:0] META_SEQ_NUM    = 8'h00;
  localparam logic [7:0] META_TRACK_NAME = 8'h03;
  localparam logic [7:0] META_INSTR_NAME = 8'h04;
  localparam logic [7:0] META_CHAN_PFX   = 8'h20;
  localparam logic [7:0] META_PORT       = 8'h21;
  localparam logic [7:0] META_END_TRACK  = 8'h2F;
  localparam logic [7:0] META_TEMPO      = 8'h51;
  localparam logic [7:0] META_SMPTE      = 8'h54;
  localparam logic [7:0] META_TIME_SIG   = 8'h58;
  localparam logic [7:0] META_KEY_SIG    = 8'h59;

  localparam int unsigned LenW   = 28;
  localparam int unsigned FieldW = 24;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_DATA    = 4'd1,
    PH_SX_LEN  = 4'd2,
    PH_SX_SKIP = 4'd3,
    PH_M_TYPE  = 4'd4,
    PH_M_LEN   = 4'd5,
    PH_M_TEXT  = 4'd6,
    PH_M_SKIP  = 4'd7,
    PH_M_CHECK = 4'd8,
    PH_M_FIELD = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    KIND_MSG    = 3'd0,
    KIND_SYSEX  = 3'd1,
    KIND_META   = 3'd2,
    KIND_TEXT   = 3'd3,
    KIND_ORPHAN = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [7:0]        status_value;
    logic [3:0]        channel;
    logic [7:0]        first_data;
    logic [6:0]        second_data;
    logic [3:0]        note_class;
    logic [4:0]        octave;
    logic [7:0]        meta_kind;
    logic [LenW-1:0]   meta_value;
    logic [7:0]        ts_numerator;
    logic [7:0]        ts_denominator;
    logic              format_error;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_t;

  // Number of data bytes a status takes: one or two.
  function automatic logic [1:0] need_of(input logic [7:0] status);
    logic one;
    one = (status[7:4] == 4'hC) || (status[7:4] == 4'hD) ||
          (status == ST_MTC) || (status == ST_SONG_SEL);
    return one ? 2'd1 : 2'd2;
  endfunction

  // Quotient by twelve for a seven-bit value, by reciprocal multiplication.
  function automatic logic [3:0] div12(input logic [6:0] n);
    logic [12:0] p;
    p = 13'(n) * 13'd43;
    return p[12:9];
  endfunction

  function automatic logic [3:0] mod12(input logic [6:0] n);
    logic [6:0] q12;
    q12 = 7'(div12(n) * 7'd12);
    return 4'(n - q12);
  endfunction

endpackage

FILE: design/mtep_in_stage.sv
// ----------------------------------------------------------------------------
// MIDI track event parser input stage
// Registers one incoming byte and hands it to the parse step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtep_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [7:0]        data_i,
  input  logic              take_i,
  output mtep_pkg::byte_t   byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign byte_o.valid = valid_q;
  assign byte_o.data  = data_q;

endmodule

FILE: design/mtep_parse.sv
// ----------------------------------------------------------------------------
// MIDI track event parser step
// Holds the parse state and works out the next state and any result for one
// byte combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtep_parse #(
  parameter int unsigned MAX_LENGTH_BYTES = mtep_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  output mtep_pkg::result_t res_o
);

  localparam int unsigned LenCntW = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int unsigned LenW    = mtep_pkg::LenW;
  localparam int unsigned FieldW  = mtep_pkg::FieldW;

  mtep_pkg::phase_e     phase_q, phase_d;
  logic [7:0]           rs_q, rs_d;
  logic [1:0]           need_q, need_d;
  logic [1:0]           got_q, got_d;
  logic [7:0]           first_q, first_d;
  logic [7:0]           mkind_q, mkind_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [LenCntW-1:0]   lbytes_q, lbytes_d;
  logic [LenW-1:0]      left_q, left_d;
  logic [FieldW-1:0]    field_q, field_d;
  logic [7:0]           num_q, num_d;
  logic                 err_q, err_d;

  logic [7:0]           b;
  logic                 start_msg, rs_chan;
  logic                 vlq_take, vlq_ovf, vlq_done, vlq_zero;
  logic [LenW-1:0]      vlq_accum;
  logic [LenCntW-1:0]   vlq_bytes;
  logic [LenW-1:0]      left_dec;
  logic                 left_dec_zero;
  logic                 fixed_meta, skip_meta, text_meta;
  logic [7:0]           want;
  logic [1:0]           rs_need;
  mtep_pkg::result_t    res;
  logic [6:0]           note;

  assign b = byte_i;

  always_comb begin
    start_msg = b[7] && ((b < mtep_pkg::ST_SYSEX) || (b == mtep_pkg::ST_MTC) ||
                         (b == mtep_pkg::ST_SONG_POS) || (b == mtep_pkg::ST_SONG_SEL));
    rs_chan   = rs_q[7] && (rs_q < mtep_pkg::ST_SYSEX);
    rs_need   = mtep_pkg::need_of(rs_q);

    vlq_take  = 32'(lbytes_q) < MAX_LENGTH_BYTES;
    vlq_accum = vlq_take ? {len_q[LenW-8:0], b[6:0]} : len_q;
    vlq_bytes = vlq_take ? lbytes_q + LenCntW'(1) : lbytes_q;
    vlq_ovf   = b[7] && (32'(vlq_bytes) >= MAX_LENGTH_BYTES);
    vlq_done  = !b[7] || vlq_ovf;
    vlq_zero  = (vlq_accum == '0);

    left_dec      = (left_q != '0) ? left_q - LenW'(1) : left_q;
    left_dec_zero = (left_dec == '0);

    fixed_meta = (b == mtep_pkg::META_PORT) || (b == mtep_pkg::META_END_TRACK) ||
                 (b == mtep_pkg::META_TEMPO) || (b == mtep_pkg::META_TIME_SIG);
    skip_meta  = (b == mtep_pkg::META_SEQ_NUM) || (b == mtep_pkg::META_CHAN_PFX) ||
                 (b == mtep_pkg::META_SMPTE) || (b == mtep_pkg::META_KEY_SIG);
    text_meta  = (mkind_q == mtep_pkg::META_TRACK_NAME) ||
                 (mkind_q == mtep_pkg::META_INSTR_NAME);

    if (mkind_q == mtep_pkg::META_PORT) begin
      want = 8'd1;
    end else if (mkind_q == mtep_pkg::META_TEMPO) begin
      want = 8'd3;
    end else if (mkind_q == mtep_pkg::META_TIME_SIG) begin
      want = 8'd4;
    end else begin
      want = 8'd0;
    end
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      mtep_pkg::PH_IDLE: begin
        if (b[7]) begin
          if (start_msg) begin
            phase_d = mtep_pkg::PH_DATA;
          end else if (b == mtep_pkg::ST_SYSEX) begin
            phase_d = mtep_pkg::PH_SX_LEN;
          end else if (b == mtep_pkg::ST_META) begin
            phase_d = mtep_pkg::PH_M_TYPE;
          end
        end else if (rs_chan && (rs_need == 2'd2)) begin
          phase_d = mtep_pkg::PH_DATA;
        end
      end
      mtep_pkg::PH_DATA: begin
        if (!((got_q == 2'd0) && (need_q > 2'd1))) begin
          phase_d = mtep_pkg::PH_IDLE;
        end
      end
      mtep_pkg::PH_SX_LEN: begin
        if (vlq_done) begin
          phase_d = vlq_zero ? mtep_pkg::PH_IDLE : mtep_pkg::PH_SX_SKIP;
        end
      end
      mtep_pkg::PH_M_TYPE: begin
        if (fixed_meta) begin
          phase_d = mtep_pkg::PH_M_CHECK;
        end else if (skip_meta) begin
          phase_d = mtep_pkg::PH_M_SKIP;
        end else begin
          phase_d = mtep_pkg::PH_M_LEN;
        end
      end
      mtep_pkg::PH_M_LEN: begin
        if (vlq_done) begin
          if (vlq_zero) begin
            phase_d = mtep_pkg::PH_IDLE;
          end else begin
            phase_d = text_meta ? mtep_pkg::PH_M_TEXT : mtep_pkg::PH_M_SKIP;
          end
        end
      end
      mtep_pkg::PH_SX_SKIP, mtep_pkg::PH_M_TEXT, mtep_pkg::PH_M_SKIP,
      mtep_pkg::PH_M_FIELD: begin
        if (left_dec_zero) begin
          phase_d = mtep_pkg::PH_IDLE;
        end
      end
      mtep_pkg::PH_M_CHECK: begin
        phase_d = (want == 8'd0) ? mtep_pkg::PH_IDLE : mtep_pkg::PH_M_FIELD;
      end
      default: begin
        phase_d = mtep_pkg::PH_IDLE;
      end
    endcase
  end

  // Datapath registers and result.
  always_comb begin
    rs_d     = rs_q;
    need_d   = need_q;
    got_d    = got_q;
    first_d  = first_q;
    mkind_d  = mkind_q;
    len_d    = len_q;
    lbytes_d = lbytes_q;
    left_d   = left_q;
    field_d  = field_q;
    num_d    = num_q;
    err_d    = err_q;

    res_valid_o        = 1'b0;
    res                = '0;
    res.kind           = mtep_pkg::KIND_MSG;

    case (phase_q)
      mtep_pkg::PH_IDLE: begin
        if (b[7]) begin
          if (start_msg) begin
            rs_d   = b;
            need_d = mtep_pkg::need_of(b);
            got_d  = 2'd0;
          end else if ((b == mtep_pkg::ST_SYSEX) || (b == mtep_pkg::ST_META)) begin
            rs_d     = 8'd0;
            err_d    = 1'b0;
            len_d    = '0;
            lbytes_d = '0;
          end else begin
            if (b <= mtep_pkg::ST_EOX) begin
              rs_d = 8'd0;
            end
            res_valid_o      = 1'b1;
            res.status_value = b;
          end
        end else if (rs_chan) begin
          need_d  = rs_need;
          first_d = b;
          got_d   = 2'd1;
          if (rs_need <= 2'd1) begin
            got_d            = 2'd0;
            res_valid_o      = 1'b1;
            res.status_value = rs_q;
            res.first_data   = b;
          end
        end else begin
          res_valid_o    = 1'b1;
          res.kind       = mtep_pkg::KIND_ORPHAN;
          res.first_data = b;
        end
      end
      mtep_pkg::PH_DATA: begin
        if ((got_q == 2'd0) && (need_q > 2'd1)) begin
          first_d = b;
          got_d   = 2'd1;
        end else begin
          got_d            = 2'd0;
          res_valid_o      = 1'b1;
          res.status_value = rs_q;
          if (rs_q >= mtep_pkg::ST_SYSEX) begin
            rs_d = 8'd0;
          end
          if (got_q == 2'd0) begin
            first_d        = b;
            res.first_data = b;
          end else begin
            res.first_data  = first_q;
            res.second_data = b[6:0];
          end
        end
      end
      mtep_pkg::PH_SX_LEN: begin
        len_d    = vlq_accum;
        lbytes_d = vlq_bytes;
        err_d    = err_q | vlq_ovf;
        if (vlq_done) begin
          if (vlq_zero) begin
            res_valid_o      = 1'b1;
            res.kind         = mtep_pkg::KIND_SYSEX;
            res.status_value = mtep_pkg::ST_SYSEX;
            res.format_error = err_q | vlq_ovf;
          end else begin
            left_d = vlq_accum;
          end
        end
      end
      mtep_pkg::PH_SX_SKIP: begin
        left_d = left_dec;
        if (left_dec_zero) begin
          res_valid_o      = 1'b1;
          res.kind         = mtep_pkg::KIND_SYSEX;
          res.status_value = mtep_pkg::ST_SYSEX;
          res.meta_value   = len_q;
          res.format_error = err_q;
        end
      end
      mtep_pkg::PH_M_TYPE: begin
        mkind_d = b;
        if (fixed_meta) begin
          mkind_d = b;
        end else if (skip_meta) begin
          if (b == mtep_pkg::META_CHAN_PFX) begin
            len_d = LenW'(2);
          end else if (b == mtep_pkg::META_SMPTE) begin
            len_d = LenW'(6);
          end else begin
            len_d = LenW'(3);
          end
          left_d = len_d;
        end else begin
          len_d    = '0;
          lbytes_d = '0;
        end
      end
      mtep_pkg::PH_M_LEN: begin
        len_d    = vlq_accum;
        lbytes_d = vlq_bytes;
        err_d    = err_q | vlq_ovf;
        if (vlq_done) begin
          if (vlq_zero) begin
            res_valid_o      = 1'b1;
            res.kind         = mtep_pkg::KIND_META;
            res.status_value = mtep_pkg::ST_META;
            res.meta_kind    = mkind_q;
            res.format_error = err_q | vlq_ovf;
          end else begin
            left_d = vlq_accum;
          end
        end
      end
      mtep_pkg::PH_M_TEXT: begin
        left_d           = left_dec;
        res_valid_o      = 1'b1;
        res.kind         = mtep_pkg::KIND_TEXT;
        res.status_value = mtep_pkg::ST_META;
        res.first_data   = b;
        res.meta_kind    = mkind_q;
        res.format_error = err_q;
      end
      mtep_pkg::PH_M_SKIP: begin
        left_d = left_dec;
        if (left_dec_zero) begin
          res_valid_o      = 1'b1;
          res.kind         = mtep_pkg::KIND_META;
          res.status_value = mtep_pkg::ST_META;
          res.meta_kind    = mkind_q;
          res.meta_value   = len_q;
          res.format_error = err_q;
        end
      end
      mtep_pkg::PH_M_CHECK: begin
        err_d = err_q | (b != want);
        if (want == 8'd0) begin
          res_valid_o      = 1'b1;
          res.kind         = mtep_pkg::KIND_META;
          res.status_value = mtep_pkg::ST_META;
          res.meta_kind    = mkind_q;
          res.format_error = err_q | (b != want);
        end else begin
          left_d  = LenW'(want);
          field_d = '0;
          num_d   = 8'd0;
          got_d   = 2'd0;
        end
      end
      mtep_pkg::PH_M_FIELD: begin
        if (mkind_q == mtep_pkg::META_TIME_SIG) begin
          if (got_q == 2'd0) begin
            num_d = b;
          end else if (got_q == 2'd1) begin
            field_d = (b < 8'd8) ? (FieldW'(1) << b[2:0]) : '0;
          end
        end else if (mkind_q == mtep_pkg::META_TEMPO) begin
          field_d = {field_q[FieldW-9:0], b};
        end else begin
          field_d = FieldW'(b);
        end
        got_d  = got_q + 2'd1;
        left_d = left_dec;
        if (left_dec_zero) begin
          got_d            = 2'd0;
          res_valid_o      = 1'b1;
          res.kind         = mtep_pkg::KIND_META;
          res.status_value = mtep_pkg::ST_META;
          res.meta_kind    = mkind_q;
          res.format_error = err_q;
          if (mkind_q == mtep_pkg::META_TIME_SIG) begin
            res.ts_numerator   = num_d;
            res.ts_denominator = field_d[7:0];
          end else begin
            res.meta_value = LenW'(field_d);
          end
        end
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase

    res.channel = res.status_value[3:0];
    note        = res.first_data[6:0];
    if ((res.kind == mtep_pkg::KIND_MSG) &&
        ((res.status_value[7:4] == 4'h8) || (res.status_value[7:4] == 4'h9))) begin
      res.note_class = mtep_pkg::mod12(note);
      res.octave     = 5'(mtep_pkg::div12(note)) - 5'd1;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mtep_pkg::PH_IDLE;
      rs_q     <= '0;
      need_q   <= '0;
      got_q    <= '0;
      first_q  <= '0;
      mkind_q  <= '0;
      len_q    <= '0;
      lbytes_q <= '0;
      left_q   <= '0;
      field_q  <= '0;
      num_q    <= '0;
      err_q    <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      rs_q     <= rs_d;
      need_q   <= need_d;
      got_q    <= got_d;
      first_q  <= first_d;
      mkind_q  <= mkind_d;
      len_q    <= len_d;
      lbytes_q <= lbytes_d;
      left_q   <= left_d;
      field_q  <= field_d;
      num_q    <= num_d;
      err_q    <= err_d;
    end
  end

endmodule

FILE: design/mtep_out_stage.sv
// ----------------------------------------------------------------------------
// MIDI track event parser output stage
// Result register that holds a finished result until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtep_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mtep_pkg::result_t res_i,
  input  logic              ready_i,
  output logic              free_o,
  output logic              valid_o,
  output mtep_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  mtep_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: design/midi_track_event_parser_top.sv
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses standard MIDI file track events, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// The block takes one track byte per transaction (delta times removed) and
// sustains one byte per clock cycle while the output is not stalled. A byte
// passes through an input register and a parse step; any result it
// completes is registered and shown on the output in the cycle after the
// step. Running status, message lengths, sysex and meta payloads are all
// tracked in the parse step's state registers. While a result waits to be
// read, the parse step stalls and the input register holds the next byte.
`timescale 1ns / 1ps
`include "midi_track_event_parser_top_defines.svh"

module midi_track_event_parser_top #(
  parameter int unsigned MAX_LENGTH_BYTES = mtep_pkg::MAX_LENGTH_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // data_byte[7:0]
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status_value[7:0], channel[11:8], first_data[19:12], second_data[26:20],
  // note_class[30:27], octave[35:31], meta_kind[43:36], meta_value[71:44],
  // ts_numerator[79:72], ts_denominator[87:80], format_error[88], zeros above
  output logic [95:0] m_axis_tdata,
  // kind[2:0]
  output logic [2:0]  m_axis_tuser
);

  mtep_pkg::byte_t   in_byte;
  mtep_pkg::result_t step_res;
  mtep_pkg::result_t out_res;
  logic              step_valid;
  logic              out_free;
  logic              step;

  assign step = in_byte.valid && out_free;

  mtep_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .take_i  (step),
    .byte_o  (in_byte)
  );

  mtep_parse #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte.data),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  mtep_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && step_valid),
    .res_i   (step_res),
    .ready_i (m_axis_tready),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .res_o   (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {7'd0, out_res.format_error, out_res.ts_denominator,
                         out_res.ts_numerator, out_res.meta_value, out_res.meta_kind,
                         out_res.octave, out_res.note_class, out_res.second_data,
                         out_res.first_data, out_res.channel, out_res.status_value};

  `MTEP_ASSERT(a_kind_range, !m_axis_tvalid || (m_axis_tuser <= mtep_pkg::KIND_ORPHAN), "result kind out of range")
  `MTEP_ASSERT(a_note_only_msg, !m_axis_tvalid || (out_res.kind == mtep_pkg::KIND_MSG) || ((out_res.note_class == 4'd0) && (out_res.octave == 5'd0)), "note fields set on a non-message result")
  `MTEP_ASSERT(a_note_class_range, !m_axis_tvalid || (out_res.note_class < 4'd12), "note class out of range")
  `MTEP_ASSERT(a_err_kinds, !m_axis_tvalid || !((out_res.kind == mtep_pkg::KIND_MSG) || (out_res.kind == mtep_pkg::KIND_ORPHAN)) || !out_res.format_error, "format error on message or orphan result")
  `MTEP_ASSERT_NEXT(a_result_loaded, step && step_valid, m_axis_tvalid, "completed result not presented")

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the MIDI track event parser
// Drives directed and random track byte streams through the parser and checks
// every result against an in-bench model of the parse, with random idling on
// both streams in all but the last random stream, and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LEN_BYTES_MAX = mtep_pkg::MAX_LENGTH_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam logic [7:0] NOTE_OFF      = 8'h80;
  localparam logic [7:0] NOTE_ON       = 8'h90;
  localparam logic [7:0] PROG_CHANGE   = 8'hC0;
  localparam logic [7:0] CHAN_PRESSURE = 8'hD0;
  localparam logic [7:0] PITCH_BEND    = 8'hE0;
  localparam logic [7:0] LAST_CHANNEL  = 8'hEF;
  localparam logic [7:0] ST_TUNE_REQ   = 8'hF6;
  localparam logic [7:0] ST_CLOCK      = 8'hF8;
  localparam logic [7:0] LAST_SYSTEM   = 8'hFE;

  typedef logic [7:0] byte_seq_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // Parse state of the model.
  mtep_pkg::phase_e phase = mtep_pkg::PH_IDLE;
  logic [7:0]  run_status = 8'h00;
  logic [1:0]  need = 2'd0;
  logic [1:0]  got = 2'd0;
  logic [7:0]  first_hold = 8'h00;
  logic [7:0]  mkind_hold = 8'h00;
  logic [27:0] len_acc = 28'd0;
  logic [2:0]  len_cnt = 3'd0;
  logic [27:0] left = 28'd0;
  logic [23:0] fld = 24'd0;
  logic [7:0]  num_hold = 8'h00;
  logic        err_hold = 1'b0;

  mtep_pkg::result_t pending_events[$];

  bit          idle_on = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_on = 1'b0;
  int unsigned hold_count = 0;
  int unsigned rx_gap = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned kind_seen[5] = '{default: 0};

  midi_track_event_parser_top #(
    .MAX_LENGTH_BYTES(LEN_BYTES_MAX)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [1:0] data_count(input logic [7:0] st);
    if (st[7:4] == 4'hC || st[7:4] == 4'hD || st == mtep_pkg::ST_MTC ||
        st == mtep_pkg::ST_SONG_SEL) begin
      return 2'd1;
    end
    return 2'd2;
  endfunction

  function automatic bit is_fixed_meta(input logic [7:0] k);
    return k == mtep_pkg::META_PORT || k == mtep_pkg::META_END_TRACK ||
           k == mtep_pkg::META_TEMPO || k == mtep_pkg::META_TIME_SIG;
  endfunction

  function automatic bit is_skip_meta(input logic [7:0] k);
    return k == mtep_pkg::META_SEQ_NUM || k == mtep_pkg::META_CHAN_PFX ||
           k == mtep_pkg::META_SMPTE || k == mtep_pkg::META_KEY_SIG;
  endfunction

  function automatic logic [7:0] fixed_len(input logic [7:0] k);
    case (k)
      mtep_pkg::META_PORT:     return 8'd1;
      mtep_pkg::META_TEMPO:    return 8'd3;
      mtep_pkg::META_TIME_SIG: return 8'd4;
      default:                 return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] preset_skip(input logic [7:0] k);
    case (k)
      mtep_pkg::META_CHAN_PFX: return 8'd2;
      mtep_pkg::META_SMPTE:    return 8'd6;
      default:                 return 8'd3;
    endcase
  endfunction

  function automatic mtep_pkg::result_t make_event(input mtep_pkg::kind_e kind,
                                                   input logic [7:0] st,
                                                   input logic [7:0] first,
                                                   input logic [6:0] second,
                                                   input logic [7:0] mk,
                                                   input logic [27:0] mval,
                                                   input logic [7:0] num,
                                                   input logic [7:0] den,
                                                   input logic err);
    mtep_pkg::result_t ev;
    int                n;
    ev = '0;
    ev.kind = kind;
    ev.status_value = st;
    ev.channel = st[3:0];
    ev.first_data = first;
    ev.second_data = second;
    if (kind == mtep_pkg::KIND_MSG && (st[7:4] == 4'h8 || st[7:4] == 4'h9)) begin
      n = int'(first[6:0]);
      ev.note_class = 4'(n % 12);
      ev.octave = 5'(n / 12 - 1);
    end
    ev.meta_kind = mk;
    ev.meta_value = mval;
    ev.ts_numerator = num;
    ev.ts_denominator = den;
    ev.format_error = err;
    return ev;
  endfunction

  function automatic bit length_byte_done(input logic [7:0] b);
    if (len_cnt < LEN_BYTES_MAX) begin
      len_acc = {len_acc[20:0], b[6:0]};
      len_cnt = len_cnt + 3'd1;
    end
    if (!b[7]) return 1'b1;
    if (len_cnt >= LEN_BYTES_MAX) begin
      err_hold = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic end_message(input logic [7:0] first, input logic [6:0] second);
    logic [7:0] st;
    st = run_status;
    got = 2'd0;
    phase = mtep_pkg::PH_IDLE;
    if (run_status >= mtep_pkg::ST_SYSEX) run_status = 8'h00;
    pending_events.push_back(make_event(mtep_pkg::KIND_MSG, st, first, second, 8'h00,
                                        28'd0, 8'h00, 8'h00, 1'b0));
  endtask

  task automatic end_meta(input logic [27:0] mval, input logic [7:0] num,
                          input logic [7:0] den);
    phase = mtep_pkg::PH_IDLE;
    pending_events.push_back(make_event(mtep_pkg::KIND_META, mtep_pkg::ST_META, 8'h00,
                                        7'h00, mkind_hold, mval, num, den, err_hold));
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [7:0] k;
    logic [7:0] want;
    k = mkind_hold;
    case (phase)
      mtep_pkg::PH_IDLE: begin
        if (b[7]) begin
          if (b < mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_MTC ||
              b == mtep_pkg::ST_SONG_POS || b == mtep_pkg::ST_SONG_SEL) begin
            run_status = b;
            need = data_count(b);
            got = 2'd0;
            phase = mtep_pkg::PH_DATA;
          end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_META) begin
            run_status = 8'h00;
            err_hold = 1'b0;
            len_acc = 28'd0;
            len_cnt = 3'd0;
            phase = (b == mtep_pkg::ST_SYSEX) ? mtep_pkg::PH_SX_LEN : mtep_pkg::PH_M_TYPE;
          end else begin
            if (b <= mtep_pkg::ST_EOX) run_status = 8'h00;
            pending_events.push_back(make_event(mtep_pkg::KIND_MSG, b, 8'h00, 7'h00, 8'h00,
                                                28'd0, 8'h00, 8'h00, 1'b0));
          end
        end else if (run_status[7] && run_status < mtep_pkg::ST_SYSEX) begin
          need = data_count(run_status);
          first_hold = b;
          got = 2'd1;
          if (need <= 2'd1) end_message(b, 7'h00);
          else phase = mtep_pkg::PH_DATA;
        end else begin
          pending_events.push_back(make_event(mtep_pkg::KIND_ORPHAN, 8'h00, b, 7'h00, 8'h00,
                                              28'd0, 8'h00, 8'h00, 1'b0));
        end
      end
      mtep_pkg::PH_DATA: begin
        if (got == 2'd0) begin
          first_hold = b;
          got = 2'd1;
          if (need <= 2'd1) end_message(b, 7'h00);
        end else begin
          end_message(first_hold, b[6:0]);
        end
      end
      mtep_pkg::PH_SX_LEN: begin
        if (length_byte_done(b)) begin
          if (len_acc == 28'd0) begin
            phase = mtep_pkg::PH_IDLE;
            pending_events.push_back(make_event(mtep_pkg::KIND_SYSEX, mtep_pkg::ST_SYSEX,
                                                8'h00, 7'h00, 8'h00, 28'd0, 8'h00, 8'h00,
                                                err_hold));
          end else begin
            left = len_acc;
            phase = mtep_pkg::PH_SX_SKIP;
          end
        end
      end
      mtep_pkg::PH_SX_SKIP: begin
        if (left != 28'd0) left = left - 28'd1;
        if (left == 28'd0) begin
          phase = mtep_pkg::PH_IDLE;
          pending_events.push_back(make_event(mtep_pkg::KIND_SYSEX, mtep_pkg::ST_SYSEX,
                                              8'h00, 7'h00, 8'h00, len_acc, 8'h00, 8'h00,
                                              err_hold));
        end
      end
      mtep_pkg::PH_M_TYPE: begin
        mkind_hold = b;
        if (is_fixed_meta(b)) begin
          phase = mtep_pkg::PH_M_CHECK;
        end else if (is_skip_meta(b)) begin
          len_acc = 28'(preset_skip(b));
          left = len_acc;
          phase = mtep_pkg::PH_M_SKIP;
        end else begin
          len_acc = 28'd0;
          len_cnt = 3'd0;
          phase = mtep_pkg::PH_M_LEN;
        end
      end
      mtep_pkg::PH_M_LEN: begin
        if (length_byte_done(b)) begin
          if (len_acc == 28'd0) begin
            end_meta(28'd0, 8'h00, 8'h00);
          end else begin
            left = len_acc;
            if (k == mtep_pkg::META_TRACK_NAME || k == mtep_pkg::META_INSTR_NAME) begin
              phase = mtep_pkg::PH_M_TEXT;
            end else begin
              phase = mtep_pkg::PH_M_SKIP;
            end
          end
        end
      end
      mtep_pkg::PH_M_TEXT: begin
        if (left != 28'd0) left = left - 28'd1;
        if (left == 28'd0) phase = mtep_pkg::PH_IDLE;
        pending_events.push_back(make_event(mtep_pkg::KIND_TEXT, mtep_pkg::ST_META, b, 7'h00,
                                            k, 28'd0, 8'h00, 8'h00, err_hold));
      end
      mtep_pkg::PH_M_SKIP: begin
        if (left != 28'd0) left = left - 28'd1;
        if (left == 28'd0) end_meta(len_acc, 8'h00, 8'h00);
      end
      mtep_pkg::PH_M_CHECK: begin
        want = fixed_len(k);
        if (b != want) err_hold = 1'b1;
        if (want == 8'd0) begin
          end_meta(28'd0, 8'h00, 8'h00);
        end else begin
          left = 28'(want);
          fld = 24'd0;
          num_hold = 8'h00;
          got = 2'd0;
          phase = mtep_pkg::PH_M_FIELD;
        end
      end
      mtep_pkg::PH_M_FIELD: begin
        if (k == mtep_pkg::META_TIME_SIG) begin
          if (got == 2'd0) num_hold = b;
          else if (got == 2'd1) fld = (b < 8'd8) ? (24'd1 << b[2:0]) : 24'd0;
        end else if (k == mtep_pkg::META_TEMPO) begin
          fld = {fld[15:0], b};
        end else begin
          fld = 24'(b);
        end
        got = got + 2'd1;
        if (left != 28'd0) left = left - 28'd1;
        if (left == 28'd0) begin
          got = 2'd0;
          if (k == mtep_pkg::META_TIME_SIG) end_meta(28'd0, num_hold, fld[7:0]);
          else end_meta(28'(fld), 8'h00, 8'h00);
        end
      end
      default: phase = mtep_pkg::PH_IDLE;
    endcase
  endtask

  // Sender side.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_seq(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // A random byte that can never open a long payload skip.
  function automatic logic [7:0] free_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (phase == mtep_pkg::PH_SX_LEN || phase == mtep_pkg::PH_M_LEN) b = b & 8'h0F;
    return b;
  endfunction

  task automatic send_length(input int unsigned n);
    int unsigned form;
    logic [27:0] v;
    form = $urandom_range(0, 9);
    v = 28'(n);
    if (form < 8) begin
      if (n >= 128) send_byte({1'b1, v[13:7]});
      send_byte({1'b0, v[6:0]});
    end else begin
      send_byte({1'b1, v[27:21]});
      send_byte({1'b1, v[20:14]});
      send_byte({1'b1, v[13:7]});
      send_byte({form == 9, v[6:0]});
    end
  endtask

  task automatic send_sysex_event();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 12);
    send_byte(mtep_pkg::ST_SYSEX);
    send_length(n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_meta_event();
    logic [7:0] k;
    logic [7:0] want;
    int unsigned n;
    case ($urandom_range(0, 10))
      0: k = mtep_pkg::META_SEQ_NUM;
      1: k = mtep_pkg::META_TRACK_NAME;
      2: k = mtep_pkg::META_INSTR_NAME;
      3: k = mtep_pkg::META_CHAN_PFX;
      4: k = mtep_pkg::META_PORT;
      5: k = mtep_pkg::META_END_TRACK;
      6: k = mtep_pkg::META_TEMPO;
      7: k = mtep_pkg::META_TIME_SIG;
      8: k = mtep_pkg::META_SMPTE;
      9: k = mtep_pkg::META_KEY_SIG;
      default: k = 8'($urandom_range(0, 255));
    endcase
    send_byte(mtep_pkg::ST_META);
    send_byte(k);
    if (is_fixed_meta(k)) begin
      want = fixed_len(k);
      send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : want);
      for (int i = 0; i < int'(want); i++) begin
        if (k == mtep_pkg::META_TIME_SIG && i == 1) begin
          send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(0, 7)));
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
      end
    end else if (is_skip_meta(k)) begin
      send_byte(preset_skip(k) - 8'd1);
      repeat (preset_skip(k) - 8'd1) send_byte(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 14);
      send_length(n);
      repeat (n) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_channel_event();
    logic [7:0] st;
    if (run_status[7] && run_status < mtep_pkg::ST_SYSEX && $urandom_range(0, 2) == 0) begin
      st = run_status;
    end else begin
      st = 8'($urandom_range(NOTE_OFF, LAST_CHANNEL));
      send_byte(st);
    end
    repeat (data_count(st)) begin
      send_byte(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 127)));
    end
  endtask

  task automatic send_system_event();
    logic [7:0] st;
    st = 8'($urandom_range(mtep_pkg::ST_MTC, LAST_SYSTEM));
    send_byte(st);
    if (st == mtep_pkg::ST_MTC || st == mtep_pkg::ST_SONG_SEL ||
        st == mtep_pkg::ST_SONG_POS) begin
      repeat (data_count(st)) send_byte(8'($urandom_range(0, 127)));
    end
  endtask

  task automatic send_random_event();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick >= 95) begin
      repeat ($urandom_range(1, 4)) send_byte(free_byte());
    end else begin
      while (phase != mtep_pkg::PH_IDLE) send_byte(free_byte());
      if (pick < 40) send_channel_event();
      else if (pick < 48) send_system_event();
      else if (pick < 58) send_sysex_event();
      else if (pick < 90) send_meta_event();
      else send_byte(8'($urandom_range(0, 127)));
    end
  endtask

  // Receiver side.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_on) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        m_axis_tready <= 1'b0;
        rx_gap--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        rx_gap = $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_on) begin
        hold_on = 1'b1;
        hold_count = HOLD_CYCLES;
      end else if (hold_on) begin
        hold_count--;
        if (hold_count == 0) begin
          hold_on = 1'b0;
          hold_req = 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input string detail);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("tb_top: mismatch at %0t: %s %s", $time, what,
                                            detail);
  endtask

  function automatic string describe(input mtep_pkg::result_t r);
    return $sformatf({"kind=%0d st=%h ch=%h d1=%h d2=%h nc=%0d oct=%h mk=%h mv=%h",
                      " num=%h den=%h e=%b"},
                     r.kind, r.status_value, r.channel, r.first_data, r.second_data,
                     r.note_class, r.octave, r.meta_kind, r.meta_value, r.ts_numerator,
                     r.ts_denominator, r.format_error);
  endfunction

  always @(posedge clk_i) begin : check_results
    mtep_pkg::result_t seen;
    mtep_pkg::result_t want;
    string             bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.kind           = mtep_pkg::kind_e'(m_axis_tuser);
      seen.status_value   = m_axis_tdata[7:0];
      seen.channel        = m_axis_tdata[11:8];
      seen.first_data     = m_axis_tdata[19:12];
      seen.second_data    = m_axis_tdata[26:20];
      seen.note_class     = m_axis_tdata[30:27];
      seen.octave         = m_axis_tdata[35:31];
      seen.meta_kind      = m_axis_tdata[43:36];
      seen.meta_value     = m_axis_tdata[71:44];
      seen.ts_numerator   = m_axis_tdata[79:72];
      seen.ts_denominator = m_axis_tdata[87:80];
      seen.format_error   = m_axis_tdata[88];
      results_seen++;
      if (m_axis_tuser < 3'd5) kind_seen[m_axis_tuser]++;
      if (pending_events.size() == 0) begin
        report_mismatch("result with nothing expected:", describe(seen));
      end else begin
        want = pending_events.pop_front();
        bad = "";
        if (seen.kind !== want.kind) bad = {bad, " kind"};
        if (seen.status_value !== want.status_value) bad = {bad, " status"};
        if (seen.channel !== want.channel) bad = {bad, " channel"};
        if (seen.first_data !== want.first_data) bad = {bad, " first_data"};
        if (seen.second_data !== want.second_data) bad = {bad, " second_data"};
        if (seen.note_class !== want.note_class) bad = {bad, " note_class"};
        if (seen.octave !== want.octave) bad = {bad, " octave"};
        if (seen.meta_kind !== want.meta_kind) bad = {bad, " meta_kind"};
        if (seen.meta_value !== want.meta_value) bad = {bad, " meta_value"};
        if (seen.ts_numerator !== want.ts_numerator) bad = {bad, " ts_numerator"};
        if (seen.ts_denominator !== want.ts_denominator) bad = {bad, " ts_denominator"};
        if (seen.format_error !== want.format_error) bad = {bad, " format_error"};
        if (bad != "") begin
          report_mismatch({"field", bad, ":"}, {"expected ", describe(want), " actual ",
                                               describe(seen)});
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_top: timeout after %0d cycles, %0d results outstanding", cycle_count,
             pending_events.size());
    $display("tb_top: FAIL");
    $finish;
  end

  // Directed tests.
  task automatic test_channel_messages();
    send_seq({NOTE_ON, 8'h00, 8'h7F});
    send_seq({8'h7F, 8'h00});
    send_seq({NOTE_OFF | 8'h0F, 8'h3C, 8'h40});
    send_seq({PROG_CHANGE | 8'h05, 8'h7F});
    send_seq({CHAN_PRESSURE, 8'hFF});
    send_seq({PITCH_BEND | 8'h03, NOTE_ON, 8'hFF});
  endtask

  task automatic test_system_messages();
    send_seq({ST_CLOCK, 8'h01, 8'h02});
    send_seq({mtep_pkg::ST_SONG_POS, 8'h01, 8'h7F, mtep_pkg::ST_MTC, 8'h05, ST_TUNE_REQ,
              8'h7F, 8'h00});
  endtask

  task automatic test_sysex();
    send_seq({mtep_pkg::ST_SYSEX, 8'h00});
    send_seq({mtep_pkg::ST_SYSEX, 8'h03, 8'hAA, 8'hBB, mtep_pkg::ST_EOX});
    send_seq({mtep_pkg::ST_SYSEX, 8'h80, 8'h80, 8'h80, 8'h81, 8'hFF});
  endtask

  task automatic test_meta_events();
    send_seq({mtep_pkg::ST_META, mtep_pkg::META_END_TRACK, 8'h00});
    send_seq({mtep_pkg::ST_META, mtep_pkg::META_TEMPO, 8'h03, 8'hFF, 8'hFF, 8'hFF});
    send_seq({mtep_pkg::ST_META, mtep_pkg::META_TIME_SIG, 8'h04, 8'h06, 8'h03, 8'h18,
              8'h08});
    send_seq({mtep_pkg::ST_META, mtep_pkg::META_TIME_SIG, 8'h04, 8'hFF, 8'h08, 8'h00,
              8'h00});
    send_seq({mtep_pkg::ST_META, mtep_pkg::META_PORT, 8'h02, 8'h05});
    send_seq({mtep_pkg::ST_META, mtep_pkg::META_TRACK_NAME, 8'h00});
    send_seq({mtep_pkg::ST_META, mtep_pkg::META_INSTR_NAME, 8'h02, 8'h41, 8'hC2});
    send_seq({mtep_pkg::ST_META, mtep_pkg::META_KEY_SIG, 8'h02, 8'h00, 8'h00});
    send_seq({mtep_pkg::ST_META, 8'h7F, 8'h80, 8'h80, 8'h80, 8'h02, 8'hAA, 8'hBB});
  endtask

  task automatic test_random_stream(input int unsigned count);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < count) send_random_event();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    test_random_stream(150);
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_on = 1'b1;
    test_channel_messages();
    test_system_messages();
    test_sysex();
    test_meta_events();
    test_random_stream(700);
    test_backpressure();
    idle_on = 1'b0;
    test_random_stream(350);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    $display("tb_top: %0d track bytes sent, %0d results checked, %0d mismatches", bytes_sent,
             results_seen, mismatches);
    $display("tb_top: results by kind: %0d messages, %0d sysex, %0d meta, %0d text, %0d orphan",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/mtep_pkg.sv
design/mtep_in_stage.sv
design/mtep_parse.sv
design/mtep_out_stage.sv
design/midi_track_event_parser_top.sv
verif/tb_top.sv
